// ----- hw/rtl/biquad_iir_pcm_filter_macros.svh -----
// ----------------------------------------------------------------------------
// biquad iir pcm filter assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_PCM_FILTER_MACROS_SVH
`define BIQUAD_IIR_PCM_FILTER_MACROS_SVH

// same-cycle implication
`define BQF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bqf assertion failed");

// next-cycle implication
`define BQF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bqf assertion failed");

`endif

// ----- hw/rtl/bqf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_pkg
// widths, fixed-point constants, register map and shared types of the filter
// ----------------------------------------------------------------------------
package bqf_pkg;

    localparam int SampleW   = 16;
    localparam int CoefW     = 24;
    localparam int HistW     = 32;
    localparam int AccW      = HistW + CoefW + 2;
    localparam int FracShift = 21;
    localparam int FfShift   = 9;
    localparam int YWideW    = AccW - FracShift;
    localparam int UnitShift = 24;
    localparam int MagW      = UnitShift + 1;
    localparam int PcmShift  = 15;
    localparam int ProdW     = MagW + PcmShift;

    localparam logic signed [HistW-1:0] UnitQ24    = HistW'(64'sd16777216);
    localparam logic signed [HistW-1:0] NegUnitQ24 = HistW'(-64'sd16777216);

    // apb register map
    localparam int DataW   = 32;
    localparam int AddrW   = 5;
    localparam int RegIdxW = 3;

    localparam logic [RegIdxW-1:0] RegB0 = 3'd0;
    localparam logic [RegIdxW-1:0] RegB1 = 3'd1;
    localparam logic [RegIdxW-1:0] RegB2 = 3'd2;
    localparam logic [RegIdxW-1:0] RegA1 = 3'd3;
    localparam logic [RegIdxW-1:0] RegA2 = 3'd4;

    localparam logic [CoefW-1:0] B0Reset = 24'h200000;

    typedef struct packed {
        logic signed [CoefW-1:0] b0;
        logic signed [CoefW-1:0] b1;
        logic signed [CoefW-1:0] b2;
        logic signed [CoefW-1:0] a1;
        logic signed [CoefW-1:0] a2;
    } coef_t;

    typedef struct packed {
        logic signed [HistW-1:0] y;
        logic                    last;
    } hist_beat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bqf_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_in_if
// input sample channel: valid/ready with pcm sample and end-of-buffer mark
// ----------------------------------------------------------------------------
interface bqf_in_if;

    logic                               valid;
    logic                               ready;
    logic signed [bqf_pkg::SampleW-1:0] sample_in;
    logic                               end_of_buffer;

    modport source (output valid, output sample_in, output end_of_buffer, input ready);
    modport sink   (input valid, input sample_in, input end_of_buffer, output ready);

endinterface

`default_nettype wire

// ----- hw/rtl/bqf_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_out_if
// filtered sample channel: valid/ready with pcm sample and last mark
// ----------------------------------------------------------------------------
interface bqf_out_if;

    logic                               valid;
    logic                               ready;
    logic signed [bqf_pkg::SampleW-1:0] sample_out;
    logic                               last_out;

    modport source (output valid, output sample_out, output last_out, input ready);
    modport sink   (input valid, input sample_out, input last_out, output ready);

endinterface

`default_nettype wire

// ----- hw/rtl/bqf_apb_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_apb_cfg
// apb coefficient registers b0, b1, b2, a1, a2 with sign-extended readback
// ----------------------------------------------------------------------------
module bqf_apb_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bqf_pkg::AddrW-1:0]   paddr,
    input  logic [bqf_pkg::DataW-1:0]   pwdata,
    output logic [bqf_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    output bqf_pkg::coef_t              coef
);

    bqf_pkg::coef_t                 coef_reg;
    logic                           wr_en;
    logic [bqf_pkg::RegIdxW-1:0]    reg_idx;
    logic [bqf_pkg::CoefW-1:0]      rd_coef;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[bqf_pkg::AddrW-1:2];
    assign coef    = coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= bqf_pkg::B0Reset;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                bqf_pkg::RegB0: coef_reg.b0 <= pwdata[bqf_pkg::CoefW-1:0];
                bqf_pkg::RegB1: coef_reg.b1 <= pwdata[bqf_pkg::CoefW-1:0];
                bqf_pkg::RegB2: coef_reg.b2 <= pwdata[bqf_pkg::CoefW-1:0];
                bqf_pkg::RegA1: coef_reg.a1 <= pwdata[bqf_pkg::CoefW-1:0];
                bqf_pkg::RegA2: coef_reg.a2 <= pwdata[bqf_pkg::CoefW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            bqf_pkg::RegB0: rd_coef = coef_reg.b0;
            bqf_pkg::RegB1: rd_coef = coef_reg.b1;
            bqf_pkg::RegB2: rd_coef = coef_reg.b2;
            bqf_pkg::RegA1: rd_coef = coef_reg.a1;
            bqf_pkg::RegA2: rd_coef = coef_reg.a2;
            default:        rd_coef = '0;
        endcase
    end

    assign prdata = {{(bqf_pkg::DataW - bqf_pkg::CoefW){rd_coef[bqf_pkg::CoefW-1]}}, rd_coef};

endmodule

`default_nettype wire

// ----- hw/rtl/bqf_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_core
// input register, direct-form-i sum of products with saturated q8.24 result,
// and the four history registers that clear after an end-of-buffer beat
// ----------------------------------------------------------------------------
`include "biquad_iir_pcm_filter_macros.svh"

module bqf_core (
    input  logic                clk,
    input  logic                rst_n,
    input  bqf_pkg::coef_t      coef,
    bqf_in_if.sink              samples,
    output logic                beat_valid,
    input  logic                beat_ready,
    output bqf_pkg::hist_beat_t beat
);

    // input stage
    logic                               a_valid_reg;
    logic signed [bqf_pkg::SampleW-1:0] x_reg;
    logic                               last_a_reg;
    logic                               a_ready;

    // result stage
    logic                               b_valid_reg;
    bqf_pkg::hist_beat_t                b_beat_reg;
    logic                               b_ready;
    logic                               fire_b;

    // history
    logic signed [bqf_pkg::SampleW-1:0] prev_in_1_reg, prev_in_1_next;
    logic signed [bqf_pkg::SampleW-1:0] prev_in_2_reg, prev_in_2_next;
    logic signed [bqf_pkg::HistW-1:0]   prev_out_1_reg, prev_out_1_next;
    logic signed [bqf_pkg::HistW-1:0]   prev_out_2_reg, prev_out_2_next;

    // datapath
    logic signed [bqf_pkg::SampleW+bqf_pkg::CoefW-1:0] p_b0, p_b1, p_b2;
    logic signed [bqf_pkg::HistW+bqf_pkg::CoefW-1:0]   p_a1, p_a2;
    logic signed [bqf_pkg::AccW-1:0]                   ff_sum;
    logic signed [bqf_pkg::AccW-1:0]                   acc;
    logic signed [bqf_pkg::YWideW-1:0]                 y_wide;
    logic [bqf_pkg::YWideW-bqf_pkg::HistW:0]           y_top;
    logic signed [bqf_pkg::HistW-1:0]                  y_sat;

    assign b_ready       = !b_valid_reg || beat_ready;
    assign fire_b        = a_valid_reg && b_ready;
    assign a_ready       = !a_valid_reg || b_ready;
    assign samples.ready = a_ready;
    assign beat_valid    = b_valid_reg;
    assign beat          = b_beat_reg;

    assign p_b0 = $signed(coef.b0) * x_reg;
    assign p_b1 = $signed(coef.b1) * prev_in_1_reg;
    assign p_b2 = $signed(coef.b2) * prev_in_2_reg;
    assign p_a1 = $signed(coef.a1) * prev_out_1_reg;
    assign p_a2 = $signed(coef.a2) * prev_out_2_reg;

    assign ff_sum = bqf_pkg::AccW'(p_b0) + bqf_pkg::AccW'(p_b1) + bqf_pkg::AccW'(p_b2);
    assign acc    = (ff_sum <<< bqf_pkg::FfShift) - bqf_pkg::AccW'(p_a1)
                    - bqf_pkg::AccW'(p_a2);

    // floor shift to q8.24
    assign y_wide = $signed(acc[bqf_pkg::AccW-1:bqf_pkg::FracShift]);
    assign y_top  = y_wide[bqf_pkg::YWideW-1:bqf_pkg::HistW-1];

    always_comb
    begin
        if ((&y_top) || !(|y_top))
        begin
            y_sat = y_wide[bqf_pkg::HistW-1:0];
        end
        else if (y_wide[bqf_pkg::YWideW-1])
        begin
            y_sat = {1'b1, {(bqf_pkg::HistW-1){1'b0}}};
        end
        else
        begin
            y_sat = {1'b0, {(bqf_pkg::HistW-1){1'b1}}};
        end
    end

    always_comb
    begin
        prev_in_1_next  = x_reg;
        prev_in_2_next  = prev_in_1_reg;
        prev_out_1_next = y_sat;
        prev_out_2_next = prev_out_1_reg;
        if (last_a_reg)
        begin
            prev_in_1_next  = '0;
            prev_in_2_next  = '0;
            prev_out_1_next = '0;
            prev_out_2_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            prev_in_1_reg  <= '0;
            prev_in_2_reg  <= '0;
            prev_out_1_reg <= '0;
            prev_out_2_reg <= '0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= samples.valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (fire_b)
            begin
                prev_in_1_reg  <= prev_in_1_next;
                prev_in_2_reg  <= prev_in_2_next;
                prev_out_1_reg <= prev_out_1_next;
                prev_out_2_reg <= prev_out_2_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && samples.valid)
        begin
            x_reg      <= samples.sample_in;
            last_a_reg <= samples.end_of_buffer;
        end
        if (fire_b)
        begin
            b_beat_reg.y    <= y_sat;
            b_beat_reg.last <= last_a_reg;
        end
    end

    `BQF_ASSERT_NXT(a_hist_clear, fire_b && last_a_reg,
        prev_in_1_reg == '0 && prev_in_2_reg == '0 && prev_out_1_reg == '0 && prev_out_2_reg == '0)
    `BQF_ASSERT_NXT(a_hist_track, fire_b && !last_a_reg,
        prev_out_1_reg == b_beat_reg.y && prev_in_1_reg == $past(x_reg))
    `BQF_ASSERT_NXT(a_hist_hold, !fire_b,
        $stable(prev_out_1_reg) && $stable(prev_out_2_reg) && $stable(prev_in_1_reg))

endmodule

`default_nettype wire

// ----- hw/rtl/bqf_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_scale
// output stage: clamp q8.24 to unit range, scale by 32767 toward zero,
// hold the pcm beat in the output register
// ----------------------------------------------------------------------------
`include "biquad_iir_pcm_filter_macros.svh"

module bqf_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                beat_valid,
    output logic                beat_ready,
    input  bqf_pkg::hist_beat_t beat,
    bqf_out_if.source           filtered
);

    logic                               c_valid_reg;
    logic signed [bqf_pkg::SampleW-1:0] sample_out_reg, sample_out_next;
    logic                               last_out_reg;
    logic                               c_ready;

    logic signed [bqf_pkg::HistW-1:0]   clamped;
    logic                               neg;
    logic [bqf_pkg::MagW-1:0]           mag;
    logic [bqf_pkg::ProdW-1:0]          prod;
    logic [bqf_pkg::SampleW-1:0]        q;

    assign c_ready    = !c_valid_reg || filtered.ready;
    assign beat_ready = c_ready;

    assign filtered.valid      = c_valid_reg;
    assign filtered.sample_out = sample_out_reg;
    assign filtered.last_out   = last_out_reg;

    always_comb
    begin
        if (beat.y > bqf_pkg::UnitQ24)
        begin
            clamped = bqf_pkg::UnitQ24;
        end
        else if (beat.y < bqf_pkg::NegUnitQ24)
        begin
            clamped = bqf_pkg::NegUnitQ24;
        end
        else
        begin
            clamped = beat.y;
        end
    end

    assign neg  = clamped[bqf_pkg::HistW-1];
    assign mag  = neg ? bqf_pkg::MagW'(-clamped) : bqf_pkg::MagW'(clamped);
    // mag * 32767 as shift and subtract
    assign prod = (bqf_pkg::ProdW'(mag) << bqf_pkg::PcmShift) - bqf_pkg::ProdW'(mag);
    assign q    = prod[bqf_pkg::ProdW-1:bqf_pkg::UnitShift];

    assign sample_out_next = neg ? $signed(~q + bqf_pkg::SampleW'(1)) : $signed(q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= beat_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && beat_valid)
        begin
            sample_out_reg <= sample_out_next;
            last_out_reg   <= beat.last;
        end
    end

    `BQF_ASSERT_IMP(a_pcm_range, c_valid_reg,
        sample_out_reg != {1'b1, {(bqf_pkg::SampleW-1){1'b0}}})

endmodule

`default_nettype wire

// ----- hw/rtl/biquad_iir_pcm_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_iir_pcm_filter
// direct-form-i biquad on 16-bit pcm with apb coefficient registers
// ----------------------------------------------------------------------------
// Takes one sample per clock while the output is not stalled and returns one
// filtered sample per sample, in order; a sample passes through the input
// register, the filter register and the output register. The clock is set by
// the feedback loop from the stored outputs through the a1 and a2 multipliers,
// the sum and the saturation back into the history registers.
// Coefficients are signed Q3.21 at byte addresses 0, 4, 8, 12 and 16 (b0,
// b1, b2, a1, a2); write them only while no samples are in flight. After a
// sample marked end_of_buffer the history clears, so each buffer starts
// from rest.
module biquad_iir_pcm_filter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bqf_pkg::AddrW-1:0]   paddr,
    input  logic [bqf_pkg::DataW-1:0]   pwdata,
    output logic [bqf_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    bqf_in_if.sink                      samples,
    bqf_out_if.source                   filtered
);

    bqf_pkg::coef_t      coef;
    logic                beat_valid;
    logic                beat_ready;
    bqf_pkg::hist_beat_t beat;

    bqf_apb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    bqf_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef       (coef),
        .samples    (samples),
        .beat_valid (beat_valid),
        .beat_ready (beat_ready),
        .beat       (beat)
    );

    bqf_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat_ready (beat_ready),
        .beat       (beat),
        .filtered   (filtered)
    );

endmodule

`default_nettype wire
